// ===== design/lattice_chain_contact_energy_macros.svh =====
// ----------------------------------------------------------------------------
// lattice_chain_contact_energy_macros.svh
// Assertion macros for the lattice chain contact energy block.
// ----------------------------------------------------------------------------
`ifndef LATTICE_CHAIN_CONTACT_ENERGY_MACROS_SVH
`define LATTICE_CHAIN_CONTACT_ENERGY_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define LCCE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lcce assertion failed");
// Next-cycle implication.
`define LCCE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lcce assertion failed");
`else
`define LCCE_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define LCCE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== design/lcce_pkg.sv =====
// ----------------------------------------------------------------------------
// lcce_pkg
// Constants, types and step decoding shared by the contact energy pipeline.
// ----------------------------------------------------------------------------
package lcce_pkg;

   localparam int CHAIN_LENGTH = 12;
   localparam int MOVES_W      = 22;
   localparam int MOVE_CODES   = MOVES_W / 2;
   localparam int HALF         = CHAIN_LENGTH / 2;
   localparam int PAIR_BITS    = 25;
   localparam int COUNT_W      = 5;
   localparam int ENERGY_W     = 13;
   localparam int WEIGHT_W     = 8;
   localparam int COORD_W      = $clog2(CHAIN_LENGTH) + 1;

   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int REG_SEL_BIT  = 2;

   localparam logic REG_NATIVE_MASK    = 1'b0;
   localparam logic REG_CONTACT_WEIGHT = 1'b1;

   localparam logic [1:0] MOVE_PX = 2'd0;
   localparam logic [1:0] MOVE_PY = 2'd1;
   localparam logic [1:0] MOVE_NY = 2'd2;
   localparam logic [1:0] MOVE_NX = 2'd3;

   typedef logic        [MOVES_W-1:0]   moves_type;
   typedef logic signed [COORD_W-1:0]   coord_type;
   typedef coord_type                   coord_vec_type [CHAIN_LENGTH];
   typedef logic        [PAIR_BITS-1:0] map_type;
   typedef logic        [COUNT_W-1:0]   count_type;
   typedef logic signed [ENERGY_W-1:0]  energy_type;
   typedef logic signed [WEIGHT_W-1:0]  weight_type;

   localparam weight_type WEIGHT_RESET = '1;

   typedef struct packed {
      map_type    native_mask;
      weight_type weight;
   } csr_type;

   function automatic coord_type step_dx(input logic [1:0] code);
      coord_type d;
      case (code)
         MOVE_PX: d = coord_type'(1);
         MOVE_NX: d = coord_type'(-1);
         default: d = '0;
      endcase
      return d;
   endfunction

   function automatic coord_type step_dy(input logic [1:0] code);
      coord_type d;
      case (code)
         MOVE_PY: d = coord_type'(1);
         MOVE_NY: d = coord_type'(-1);
         default: d = '0;
      endcase
      return d;
   endfunction

endpackage

// ===== design/lcce_channels.sv =====
// ----------------------------------------------------------------------------
// lcce_channels
// Valid/ready channel interfaces for requests and results.
// ----------------------------------------------------------------------------
interface lcce_req_if;
   import lcce_pkg::*;
   logic      valid;
   logic      ready;
   moves_type moves;
   modport source (output valid, output moves, input ready);
   modport sink   (input valid, input moves, output ready);
endinterface

interface lcce_rsp_if;
   import lcce_pkg::*;
   logic       valid;
   logic       ready;
   energy_type energy;
   count_type  contact_count;
   map_type    contact_map;
   modport source (output valid, output energy, output contact_count, output contact_map,
                   input ready);
   modport sink   (input valid, input energy, input contact_count, input contact_map,
                   output ready);
endinterface

// ===== design/lcce_walk.sv =====
// ----------------------------------------------------------------------------
// lcce_walk
// Two-stage walk: half-chain prefix sums, then offset of the second half.
// ----------------------------------------------------------------------------
module lcce_walk (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  lcce_pkg::moves_type    moves,
   output logic                   out_valid,
   input  logic                   out_ready,
   output lcce_pkg::coord_vec_type x_out,
   output lcce_pkg::coord_vec_type y_out
);
   import lcce_pkg::*;

   logic          v1_ff, v2_ff;
   logic          ready1, ready2;
   coord_vec_type x1_in, y1_in, x1_ff, y1_ff;
   coord_vec_type x2_in, y2_in, x2_ff, y2_ff;

   assign ready2   = !v2_ff || out_ready;
   assign ready1   = !v1_ff || ready2;
   assign in_ready = ready1;

   // First half from the origin, second half relative to the middle residue.
   always_comb begin
      logic [1:0] code;
      coord_type  cx, cy;
      cx = '0;
      cy = '0;
      x1_in[0] = '0;
      y1_in[0] = '0;
      for (int r = 1; r < CHAIN_LENGTH; r++) begin
         if (r == HALF + 1) begin
            cx = '0;
            cy = '0;
         end
         code = (r - 1 < MOVE_CODES) ? moves[2*(r-1) +: 2] : MOVE_PX;
         cx = cx + step_dx(code);
         cy = cy + step_dy(code);
         x1_in[r] = cx;
         y1_in[r] = cy;
      end
   end

   always_comb begin
      for (int r = 0; r < CHAIN_LENGTH; r++) begin
         if (r > HALF) begin
            x2_in[r] = x1_ff[r] + x1_ff[HALF];
            y2_in[r] = y1_ff[r] + y1_ff[HALF];
         end else begin
            x2_in[r] = x1_ff[r];
            y2_in[r] = y1_ff[r];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (ready1) v1_ff <= in_valid;
         if (ready2) v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1 && in_valid) begin
         x1_ff <= x1_in;
         y1_ff <= y1_in;
      end
      if (ready2 && v1_ff) begin
         x2_ff <= x2_in;
         y2_ff <= y2_in;
      end
   end

   assign out_valid = v2_ff;
   assign x_out     = x2_ff;
   assign y_out     = y2_ff;

endmodule

// ===== design/lcce_pairs.sv =====
// ----------------------------------------------------------------------------
// lcce_pairs
// One stage of parallel adjacency tests over all residue pairs with an odd gap of at least three.
// ----------------------------------------------------------------------------
module lcce_pairs (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  lcce_pkg::coord_vec_type x_in,
   input  lcce_pkg::coord_vec_type y_in,
   output logic                    out_valid,
   input  logic                    out_ready,
   output lcce_pkg::map_type       map_out
);
   import lcce_pkg::*;

   logic    v_ff;
   map_type map_in, map_ff;

   assign in_ready = !v_ff || out_ready;

   // Bits run by i ascending, then j = i+3, i+5, ...
   always_comb begin
      int                  pb;
      logic signed [COORD_W:0] dx, dy;
      pb     = 0;
      map_in = '0;
      for (int i = 0; i < CHAIN_LENGTH; i++) begin
         for (int j = i + 3; j < CHAIN_LENGTH; j += 2) begin
            dx = $signed({x_in[i][COORD_W-1], x_in[i]}) - $signed({x_in[j][COORD_W-1], x_in[j]});
            dy = $signed({y_in[i][COORD_W-1], y_in[i]}) - $signed({y_in[j][COORD_W-1], y_in[j]});
            if (pb < PAIR_BITS) begin
               map_in[pb] = ((dx == 0) && ((dy == 1) || (dy == -1))) ||
                            ((dy == 0) && ((dx == 1) || (dx == -1)));
            end
            pb = pb + 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         map_ff <= map_in;
      end
   end

   assign out_valid = v_ff;
   assign map_out   = map_ff;

endmodule

// ===== design/lcce_score.sv =====
// ----------------------------------------------------------------------------
// lcce_score
// Native contact count, then weighted energy; the last stage is the output.
// ----------------------------------------------------------------------------
module lcce_score (
   input  logic                 clock,
   input  logic                 reset,
   input  lcce_pkg::csr_type    cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  lcce_pkg::map_type    map_in,
   output logic                 out_valid,
   input  logic                 out_ready,
   output lcce_pkg::energy_type energy,
   output lcce_pkg::count_type  contact_count,
   output lcce_pkg::map_type    contact_map
);
   import lcce_pkg::*;

   logic       v4_ff, v5_ff;
   logic       ready4, ready5;
   count_type  count4_in, count4_ff, count5_ff;
   map_type    map4_ff, map5_ff;
   energy_type energy5_ff;
   logic signed [WEIGHT_W+COUNT_W:0] product;

   assign ready5   = !v5_ff || out_ready;
   assign ready4   = !v4_ff || ready5;
   assign in_ready = ready4;

   assign count4_in = COUNT_W'($countones(map_in & cfg.native_mask));
   assign product   = cfg.weight * $signed({1'b0, count4_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (ready4) v4_ff <= in_valid;
         if (ready5) v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready4 && in_valid) begin
         count4_ff <= count4_in;
         map4_ff   <= map_in;
      end
      if (ready5 && v4_ff) begin
         energy5_ff <= $signed(product[ENERGY_W-1:0]);
         count5_ff  <= count4_ff;
         map5_ff    <= map4_ff;
      end
   end

   assign out_valid     = v5_ff;
   assign energy        = energy5_ff;
   assign contact_count = count5_ff;
   assign contact_map   = map5_ff;

endmodule

// ===== design/lattice_chain_contact_energy.sv =====
// ----------------------------------------------------------------------------
// lattice_chain_contact_energy
// Pipeline: 5 register stages (walk 2, pairs 1, count 1, energy multiply 1).
//   Throughput one request per cycle while the result is taken as it comes;
//   each stage advances when it is empty or the stage after it advances.
// Reset (synchronous, active high) empties the pipeline and sets the native
//   mask to 0 and the contact weight to -1.
// ----------------------------------------------------------------------------
`include "lattice_chain_contact_energy_macros.svh"

module lattice_chain_contact_energy (
   input  logic                              clock,
   input  logic                              reset,
   lcce_req_if.sink                          req_chan,
   lcce_rsp_if.source                        rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lcce_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [lcce_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [lcce_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import lcce_pkg::*;

   // Configuration registers.
   map_type    mask_ff;
   weight_type weight_ff;
   csr_type    cfg;
   logic       csr_write;

   // Stage handshakes between the units.
   logic          walk_valid, walk_ready;
   logic          pair_valid, pair_ready;
   coord_vec_type walk_x, walk_y;
   map_type       pair_map;

   // Result checks used by the assertions.
   logic          rsp_count_ok;
   logic          rsp_energy_ok;

   // pready is tied high: every access completes in its access cycle.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Decode the register on the word-select bit; ignore byte offset bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff   <= '0;
         weight_ff <= WEIGHT_RESET;
      end else if (csr_write) begin
         case (csr_paddr[REG_SEL_BIT])
            REG_NATIVE_MASK:    mask_ff   <= csr_pwdata[PAIR_BITS-1:0];
            REG_CONTACT_WEIGHT: weight_ff <= csr_pwdata[WEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[REG_SEL_BIT])
         REG_NATIVE_MASK:    csr_prdata = CSR_DATA_W'(mask_ff);
         REG_CONTACT_WEIGHT: csr_prdata = CSR_DATA_W'(unsigned'(weight_ff));
         default:            csr_prdata = '0;
      endcase
   end

   assign cfg.native_mask = mask_ff;
   assign cfg.weight      = weight_ff;

   // Walk the step codes into residue coordinates.
   lcce_walk u_walk (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .moves     (req_chan.moves),
      .out_valid (walk_valid),
      .out_ready (walk_ready),
      .x_out     (walk_x),
      .y_out     (walk_y)
   );

   // Test every eligible pair for lattice adjacency.
   lcce_pairs u_pairs (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (walk_valid),
      .in_ready  (walk_ready),
      .x_in      (walk_x),
      .y_in      (walk_y),
      .out_valid (pair_valid),
      .out_ready (pair_ready),
      .map_out   (pair_map)
   );

   // Count native contacts and weight them; hold the result until taken.
   lcce_score u_score (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .in_valid      (pair_valid),
      .in_ready      (pair_ready),
      .map_in        (pair_map),
      .out_valid     (rsp_chan.valid),
      .out_ready     (rsp_chan.ready),
      .energy        (rsp_chan.energy),
      .contact_count (rsp_chan.contact_count),
      .contact_map   (rsp_chan.contact_map)
   );

   assign rsp_count_ok  = {1'b0, rsp_chan.contact_count} <=
                          (COUNT_W + 1)'($countones(rsp_chan.contact_map));
   assign rsp_energy_ok = rsp_chan.energy ==
                          energy_type'(weight_ff) *
                          energy_type'($signed({1'b0, rsp_chan.contact_count}));

   // The pipeline comes out of reset empty.
   `LCCE_ASSERT_NOW(a_empty_after_reset, clock, reset, $past(reset), !rsp_chan.valid)
   // Native count can never exceed the contacts present in the map.
   `LCCE_ASSERT_NOW(a_count_le_map, clock, reset, rsp_chan.valid, rsp_count_ok)
   // Energy is the weight times the delivered count.
   `LCCE_ASSERT_NOW(a_energy_product, clock, reset, rsp_chan.valid, rsp_energy_ok)

endmodule
